// ===== sv/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the triangle stiffness pipeline.
// ----------------------------------------------------------------------------
package cst_pkg;

   // register indexes on the csr port
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_POISSON = 1'b1;

   localparam logic [14:0] POISSON_RESET = 15'd19661;

   // quotient bits produced by the divider and width of the divisor
   localparam int QUO_W = 63;
   localparam int DVS_W = 98;

   // sideband that travels with every stiffness entry
   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
      logic       last;
      logic       degen;
      logic       dneg;
      logic       neg;
      logic       big;
   } tag_type;

endpackage

// ===== sv/cst_triangle_stiffness.sv =====
// ----------------------------------------------------------------------------
// cst_triangle_stiffness
// Plane-stress constant-strain triangle: 6x6 element stiffness, one entry
// per result beat in row-major order.
// ----------------------------------------------------------------------------
// Each triangle gives 36 result beats, one per cycle while the result port
// is not stalled; a new triangle is taken only once the sequencer is empty
// or issues the last entry of the one before, so the single result port
// sets the pace. Six stages form the area and the divisor, then each entry
// runs eleven stages of products and a 63-stage divider, one quotient bit
// per stage. A stalled result port holds the whole pipeline. Configuration
// writes are always taken and must be made while the block is idle.
module cst_triangle_stiffness (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_x_node0,
   input  logic signed [31:0] req_y_node0,
   input  logic signed [31:0] req_x_node1,
   input  logic signed [31:0] req_y_node1,
   input  logic signed [31:0] req_x_node2,
   input  logic signed [31:0] req_y_node2,
   input  logic [31:0]        req_thickness,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_row_index,
   output logic [2:0]         rsp_col_index,
   output logic signed [63:0] rsp_stiffness,
   output logic               rsp_degenerate,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_data
);

   localparam int QW = cst_pkg::QUO_W;
   localparam int DW = cst_pkg::DVS_W;

   function automatic logic signed [32:0] pick3(input logic signed [32:0] v0,
                                               input logic signed [32:0] v1,
                                               input logic signed [32:0] v2,
                                               input logic [1:0] k);
      logic signed [32:0] r;
      case (k)
         2'd0:    r = v0;
         2'd1:    r = v1;
         default: r = v2;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- csr
   logic [31:0] modulus_ff;
   logic [14:0] poisson_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '0;
         poisson_ff <= cst_pkg::POISSON_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cst_pkg::CSR_MODULUS: modulus_ff <= csr_data;
            cst_pkg::CSR_POISSON: poisson_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic [16:0]        nu_minus;
   logic [16:0]        nu_plus;
   logic signed [17:0] nu_twice_s;
   logic signed [17:0] nu_minus_s;

   assign nu_minus   = 17'd65536 - {2'b00, poisson_ff};
   assign nu_plus    = 17'd65536 + {2'b00, poisson_ff};
   assign nu_twice_s = $signed({2'b00, poisson_ff, 1'b0});
   assign nu_minus_s = $signed({1'b0, nu_minus});

   // ---------------------------------------------------------------- flow
   logic       adv;
   logic       front_adv;
   logic       seq_valid_ff;
   logic [2:0] seq_row_ff;
   logic [2:0] seq_col_ff;
   logic       seq_done;
   logic       load_ok;
   logic       rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign seq_done  = (seq_row_ff == 3'd5) && (seq_col_ff == 3'd5);
   assign load_ok   = !seq_valid_ff || seq_done;
   assign front_adv = adv && load_ok;
   assign req_ready = front_adv;

   // ---------------------------------------------------------------- F1
   logic signed [32:0] xs0, ys0, xs1, ys1, xs2, ys2;
   assign xs0 = 33'(req_x_node0);
   assign ys0 = 33'(req_y_node0);
   assign xs1 = 33'(req_x_node1);
   assign ys1 = 33'(req_y_node1);
   assign xs2 = 33'(req_x_node2);
   assign ys2 = 33'(req_y_node2);

   logic               f1_valid_ff;
   logic signed [32:0] f1_b_ff [3];
   logic signed [32:0] f1_c_ff [3];
   logic signed [32:0] f1_dx1_ff, f1_dy2_ff, f1_dx2_ff, f1_dy1_ff;
   logic [31:0]        f1_th_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         f1_b_ff[0] <= ys1 - ys2;
         f1_b_ff[1] <= ys2 - ys0;
         f1_b_ff[2] <= ys0 - ys1;
         f1_c_ff[0] <= xs2 - xs1;
         f1_c_ff[1] <= xs0 - xs2;
         f1_c_ff[2] <= xs1 - xs0;
         f1_dx1_ff  <= xs1 - xs0;
         f1_dy2_ff  <= ys2 - ys0;
         f1_dx2_ff  <= xs2 - xs0;
         f1_dy1_ff  <= ys1 - ys0;
         f1_th_ff   <= req_thickness;
      end
   end

   // ---------------------------------------------------------------- F2
   logic signed [65:0] f2_pa_in, f2_pb_in;
   logic [63:0]        f2_te_in;
   logic [32:0]        f2_k_in;

   assign f2_pa_in = f1_dx1_ff * f1_dy2_ff;
   assign f2_pb_in = f1_dx2_ff * f1_dy1_ff;
   assign f2_te_in = f1_th_ff * modulus_ff;
   assign f2_k_in  = nu_minus * nu_plus;

   logic               f2_valid_ff;
   logic signed [32:0] f2_b_ff [3];
   logic signed [32:0] f2_c_ff [3];
   logic signed [65:0] f2_pa_ff, f2_pb_ff;
   logic [63:0]        f2_te_ff;
   logic [32:0]        f2_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         f2_b_ff  <= f1_b_ff;
         f2_c_ff  <= f1_c_ff;
         f2_pa_ff <= f2_pa_in;
         f2_pb_ff <= f2_pb_in;
         f2_te_ff <= f2_te_in;
         f2_k_ff  <= f2_k_in;
      end
   end

   // ---------------------------------------------------------------- F3
   logic signed [66:0] f3_d_in;
   assign f3_d_in = 67'(f2_pa_ff) - 67'(f2_pb_ff);

   logic               f3_valid_ff;
   logic signed [32:0] f3_b_ff [3];
   logic signed [32:0] f3_c_ff [3];
   logic signed [66:0] f3_d_ff;
   logic [63:0]        f3_te_ff;
   logic [32:0]        f3_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         f3_b_ff  <= f2_b_ff;
         f3_c_ff  <= f2_c_ff;
         f3_d_ff  <= f3_d_in;
         f3_te_ff <= f2_te_ff;
         f3_k_ff  <= f2_k_ff;
      end
   end

   // ---------------------------------------------------------------- F4
   logic signed [66:0] f4_neg_d;
   logic [65:0]        f4_dabs_in;
   assign f4_neg_d   = -f3_d_ff;
   assign f4_dabs_in = f3_d_ff[66] ? f4_neg_d[65:0] : f3_d_ff[65:0];

   logic               f4_valid_ff;
   logic signed [32:0] f4_b_ff [3];
   logic signed [32:0] f4_c_ff [3];
   logic [65:0]        f4_dabs_ff;
   logic               f4_dneg_ff;
   logic               f4_degen_ff;
   logic [63:0]        f4_te_ff;
   logic [32:0]        f4_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f4_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         f4_b_ff     <= f3_b_ff;
         f4_c_ff     <= f3_c_ff;
         f4_dabs_ff  <= f4_dabs_in;
         f4_dneg_ff  <= f3_d_ff[66];
         f4_degen_ff <= (f3_d_ff == '0);
         f4_te_ff    <= f3_te_ff;
         f4_k_ff     <= f3_k_ff;
      end
   end

   // ---------------------------------------------------------------- F5
   logic [65:0] f5_lo_in, f5_hi_in;
   assign f5_lo_in = f4_dabs_ff[32:0] * f4_k_ff;
   assign f5_hi_in = f4_dabs_ff[65:33] * f4_k_ff;

   logic               f5_valid_ff;
   logic signed [32:0] f5_b_ff [3];
   logic signed [32:0] f5_c_ff [3];
   logic [65:0]        f5_lo_ff, f5_hi_ff;
   logic               f5_dneg_ff;
   logic               f5_degen_ff;
   logic [63:0]        f5_te_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f5_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f5_valid_ff <= f4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         f5_b_ff     <= f4_b_ff;
         f5_c_ff     <= f4_c_ff;
         f5_lo_ff    <= f5_lo_in;
         f5_hi_ff    <= f5_hi_in;
         f5_dneg_ff  <= f4_dneg_ff;
         f5_degen_ff <= f4_degen_ff;
         f5_te_ff    <= f4_te_ff;
      end
   end

   // ---------------------------------------------------------------- F6
   // den = |D| * (2^32 - nu^2); the divisor is twice that for rounding
   logic [96:0] f6_den_in;
   assign f6_den_in = {31'b0, f5_lo_ff} + {f5_hi_ff[63:0], 33'b0};

   logic               f6_valid_ff;
   logic signed [32:0] f6_b_ff [3];
   logic signed [32:0] f6_c_ff [3];
   logic [DW-1:0]      f6_dv_ff;
   logic               f6_dneg_ff;
   logic               f6_degen_ff;
   logic [63:0]        f6_te_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f6_valid_ff <= 1'b0;
      end else if (front_adv) begin
         f6_valid_ff <= f5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         f6_b_ff     <= f5_b_ff;
         f6_c_ff     <= f5_c_ff;
         f6_dv_ff    <= {f6_den_in, 1'b0};
         f6_dneg_ff  <= f5_dneg_ff;
         f6_degen_ff <= f5_degen_ff;
         f6_te_ff    <= f5_te_ff;
      end
   end

   // ---------------------------------------------------------------- sequencer
   logic signed [32:0] seq_b_ff [3];
   logic signed [32:0] seq_c_ff [3];
   logic [DW-1:0]      seq_dv_ff;
   logic               seq_dneg_ff;
   logic               seq_degen_ff;
   logic [63:0]        seq_te_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff <= 1'b0;
         seq_row_ff   <= '0;
         seq_col_ff   <= '0;
      end else if (adv) begin
         if (load_ok) begin
            seq_valid_ff <= f6_valid_ff;
            seq_row_ff   <= '0;
            seq_col_ff   <= '0;
         end else if (seq_col_ff == 3'd5) begin
            seq_col_ff <= '0;
            seq_row_ff <= seq_row_ff + 3'd1;
         end else begin
            seq_col_ff <= seq_col_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         seq_b_ff     <= f6_b_ff;
         seq_c_ff     <= f6_c_ff;
         seq_dv_ff    <= f6_dv_ff;
         seq_dneg_ff  <= f6_dneg_ff;
         seq_degen_ff <= f6_degen_ff;
         seq_te_ff    <= f6_te_ff;
      end
   end

   // ---------------------------------------------------------------- E0
   // pick the B-matrix columns for this row and this column
   logic signed [32:0] br, cr, bm, cm;
   assign br = pick3(seq_b_ff[0], seq_b_ff[1], seq_b_ff[2], seq_row_ff[2:1]);
   assign cr = pick3(seq_c_ff[0], seq_c_ff[1], seq_c_ff[2], seq_row_ff[2:1]);
   assign bm = pick3(seq_b_ff[0], seq_b_ff[1], seq_b_ff[2], seq_col_ff[2:1]);
   assign cm = pick3(seq_c_ff[0], seq_c_ff[1], seq_c_ff[2], seq_col_ff[2:1]);

   cst_pkg::tag_type e0_tag_in;
   always_comb begin
      e0_tag_in       = '0;
      e0_tag_in.row   = seq_row_ff;
      e0_tag_in.col   = seq_col_ff;
      e0_tag_in.last  = seq_done;
      e0_tag_in.degen = seq_degen_ff;
      e0_tag_in.dneg  = seq_dneg_ff;
   end

   logic               e0_valid_ff;
   logic signed [32:0] e0_pi_ff [3];
   logic signed [32:0] e0_pm_ff [3];
   cst_pkg::tag_type   e0_tag_ff;
   logic [63:0]        e0_te_ff;
   logic [DW-1:0]      e0_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_valid_ff <= 1'b0;
      end else if (adv) begin
         e0_valid_ff <= seq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e0_pi_ff[0] <= seq_row_ff[0] ? '0 : br;
         e0_pi_ff[1] <= seq_row_ff[0] ? cr : '0;
         e0_pi_ff[2] <= seq_row_ff[0] ? br : cr;
         e0_pm_ff[0] <= seq_col_ff[0] ? '0 : bm;
         e0_pm_ff[1] <= seq_col_ff[0] ? cm : '0;
         e0_pm_ff[2] <= seq_col_ff[0] ? bm : cm;
         e0_tag_ff   <= e0_tag_in;
         e0_te_ff    <= seq_te_ff;
         e0_dv_ff    <= seq_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E1
   // W = M * P column: elasticity rows applied to the picked column
   logic signed [50:0] e1_pm0x, e1_pm1x, e1_m0, e1_m1, e1_m2;
   assign e1_pm0x = 51'(e0_pm_ff[0]);
   assign e1_pm1x = 51'(e0_pm_ff[1]);
   assign e1_m0   = e0_pm_ff[1] * nu_twice_s;
   assign e1_m1   = e0_pm_ff[0] * nu_twice_s;
   assign e1_m2   = e0_pm_ff[2] * nu_minus_s;

   logic               e1_valid_ff;
   logic signed [50:0] e1_wv_ff [3];
   logic signed [32:0] e1_pi_ff [3];
   cst_pkg::tag_type   e1_tag_ff;
   logic [63:0]        e1_te_ff;
   logic [DW-1:0]      e1_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff <= e0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_wv_ff[0] <= (e1_pm0x <<< 17) + e1_m0;
         e1_wv_ff[1] <= e1_m1 + (e1_pm1x <<< 17);
         e1_wv_ff[2] <= e1_m2;
         e1_pi_ff    <= e0_pi_ff;
         e1_tag_ff   <= e0_tag_ff;
         e1_te_ff    <= e0_te_ff;
         e1_dv_ff    <= e0_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E2
   // split each W entry so every product stays at 26x33 bits
   logic signed [25:0] e2_lo_op [3];
   logic signed [25:0] e2_hi_op [3];
   logic signed [58:0] e2_pl_in [3];
   logic signed [58:0] e2_ph_in [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         e2_lo_op[j] = $signed({1'b0, e1_wv_ff[j][24:0]});
         e2_hi_op[j] = $signed(e1_wv_ff[j][50:25]);
         e2_pl_in[j] = e2_lo_op[j] * e1_pi_ff[j];
         e2_ph_in[j] = e2_hi_op[j] * e1_pi_ff[j];
      end
   end

   logic               e2_valid_ff;
   logic signed [58:0] e2_pl_ff [3];
   logic signed [58:0] e2_ph_ff [3];
   cst_pkg::tag_type   e2_tag_ff;
   logic [63:0]        e2_te_ff;
   logic [DW-1:0]      e2_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (adv) begin
         e2_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e2_pl_ff  <= e2_pl_in;
         e2_ph_ff  <= e2_ph_in;
         e2_tag_ff <= e1_tag_ff;
         e2_te_ff  <= e1_te_ff;
         e2_dv_ff  <= e1_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E3
   logic signed [84:0] e3_plx [3];
   logic signed [84:0] e3_phx [3];
   logic signed [84:0] e3_prod_in [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         e3_plx[j]     = 85'(e2_pl_ff[j]);
         e3_phx[j]     = 85'(e2_ph_ff[j]);
         e3_prod_in[j] = (e3_phx[j] <<< 25) + e3_plx[j];
      end
   end

   logic               e3_valid_ff;
   logic signed [84:0] e3_prod_ff [3];
   cst_pkg::tag_type   e3_tag_ff;
   logic [63:0]        e3_te_ff;
   logic [DW-1:0]      e3_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e3_valid_ff <= 1'b0;
      end else if (adv) begin
         e3_valid_ff <= e2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e3_prod_ff <= e3_prod_in;
         e3_tag_ff  <= e2_tag_ff;
         e3_te_ff   <= e2_te_ff;
         e3_dv_ff   <= e2_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E4
   logic               e4_valid_ff;
   logic signed [84:0] e4_q_ff;
   cst_pkg::tag_type   e4_tag_ff;
   logic [63:0]        e4_te_ff;
   logic [DW-1:0]      e4_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e4_valid_ff <= 1'b0;
      end else if (adv) begin
         e4_valid_ff <= e3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e4_q_ff   <= e3_prod_ff[0] + e3_prod_ff[1] + e3_prod_ff[2];
         e4_tag_ff <= e3_tag_ff;
         e4_te_ff  <= e3_te_ff;
         e4_dv_ff  <= e3_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E5
   logic signed [84:0] e5_negq;
   cst_pkg::tag_type   e5_tag_in;
   assign e5_negq = -e4_q_ff;

   always_comb begin
      e5_tag_in     = e4_tag_ff;
      e5_tag_in.neg = e4_q_ff[84] ^ e4_tag_ff.dneg;
   end

   logic               e5_valid_ff;
   logic [83:0]        e5_qa_ff;
   cst_pkg::tag_type   e5_tag_ff;
   logic [63:0]        e5_te_ff;
   logic [DW-1:0]      e5_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e5_valid_ff <= 1'b0;
      end else if (adv) begin
         e5_valid_ff <= e4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e5_qa_ff  <= e4_q_ff[84] ? e5_negq[83:0] : e4_q_ff[83:0];
         e5_tag_ff <= e5_tag_in;
         e5_te_ff  <= e4_te_ff;
         e5_dv_ff  <= e4_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E6
   // |Q| * thickness * E as six 28x32 partial products
   logic [59:0] e6_lo_in [3];
   logic [59:0] e6_hi_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e6_lo_in[k] = e5_qa_ff[28*k +: 28] * e5_te_ff[31:0];
         e6_hi_in[k] = e5_qa_ff[28*k +: 28] * e5_te_ff[63:32];
      end
   end

   logic               e6_valid_ff;
   logic [59:0]        e6_lo_ff [3];
   logic [59:0]        e6_hi_ff [3];
   cst_pkg::tag_type   e6_tag_ff;
   logic [DW-1:0]      e6_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e6_valid_ff <= 1'b0;
      end else if (adv) begin
         e6_valid_ff <= e5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e6_lo_ff  <= e6_lo_in;
         e6_hi_ff  <= e6_hi_in;
         e6_tag_ff <= e5_tag_ff;
         e6_dv_ff  <= e5_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E7
   logic               e7_valid_ff;
   logic [115:0]       e7_sl_ff, e7_sh_ff;
   cst_pkg::tag_type   e7_tag_ff;
   logic [DW-1:0]      e7_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e7_valid_ff <= 1'b0;
      end else if (adv) begin
         e7_valid_ff <= e6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e7_sl_ff  <= {56'b0, e6_lo_ff[0]} + {28'b0, e6_lo_ff[1], 28'b0}
                      + {e6_lo_ff[2], 56'b0};
         e7_sh_ff  <= {56'b0, e6_hi_ff[0]} + {28'b0, e6_hi_ff[1], 28'b0}
                      + {e6_hi_ff[2], 56'b0};
         e7_tag_ff <= e6_tag_ff;
         e7_dv_ff  <= e6_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E8
   logic               e8_valid_ff;
   logic [147:0]       e8_prod_ff;
   cst_pkg::tag_type   e8_tag_ff;
   logic [DW-1:0]      e8_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e8_valid_ff <= 1'b0;
      end else if (adv) begin
         e8_valid_ff <= e7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e8_prod_ff <= {32'b0, e7_sl_ff} + {e7_sh_ff, 32'b0};
         e8_tag_ff  <= e7_tag_ff;
         e8_dv_ff   <= e7_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E9
   // numerator 2*|Q|*t*E*2^14 + den rounds the quotient half away from zero
   logic               e9_valid_ff;
   logic [163:0]       e9_num_ff;
   cst_pkg::tag_type   e9_tag_ff;
   logic [DW-1:0]      e9_dv_ff;
   logic [DW-2:0]      e9_dv_half;

   assign e9_dv_half = e8_dv_ff[DW-1:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         e9_valid_ff <= 1'b0;
      end else if (adv) begin
         e9_valid_ff <= e8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e9_num_ff <= {1'b0, e8_prod_ff, 15'b0} + {67'b0, e9_dv_half};
         e9_tag_ff <= e8_tag_ff;
         e9_dv_ff  <= e8_dv_ff;
      end
   end

   // ---------------------------------------------------------------- E10
   // a quotient of 2^63 or more saturates, so the divider needs 63 bits only
   cst_pkg::tag_type e10_tag_in;
   always_comb begin
      e10_tag_in     = e9_tag_ff;
      e10_tag_in.big = (e9_num_ff >= {3'b0, e9_dv_ff, 63'b0});
   end

   logic               e10_valid_ff;
   logic [DW-1:0]      e10_rem_ff;
   logic [QW-1:0]      e10_bits_ff;
   cst_pkg::tag_type   e10_tag_ff;
   logic [DW-1:0]      e10_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e10_valid_ff <= 1'b0;
      end else if (adv) begin
         e10_valid_ff <= e9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e10_rem_ff  <= e9_num_ff[160:63];
         e10_bits_ff <= e9_num_ff[62:0];
         e10_tag_ff  <= e10_tag_in;
         e10_dv_ff   <= e9_dv_ff;
      end
   end

   // ---------------------------------------------------------------- divide
   logic             div_valid;
   logic [QW-1:0]    div_quo;
   cst_pkg::tag_type div_tag;

   cst_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (e10_valid_ff),
      .in_rem    (e10_rem_ff),
      .in_dvs    (e10_dv_ff),
      .in_bits   (e10_bits_ff),
      .in_tag    (e10_tag_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // ---------------------------------------------------------------- result
   logic signed [63:0] mag;
   logic signed [63:0] res_in;
   assign mag = $signed({1'b0, div_quo});

   always_comb begin
      if (div_tag.degen) begin
         res_in = '0;
      end else if (div_tag.big) begin
         res_in = div_tag.neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end else begin
         res_in = div_tag.neg ? -mag : mag;
      end
   end

   logic [2:0]         rsp_row_ff, rsp_col_ff;
   logic signed [63:0] rsp_stiff_ff;
   logic               rsp_degen_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_row_ff   <= div_tag.row;
         rsp_col_ff   <= div_tag.col;
         rsp_stiff_ff <= res_in;
         rsp_degen_ff <= div_tag.degen;
         rsp_last_ff  <= div_tag.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = rsp_row_ff;
   assign rsp_col_index  = rsp_col_ff;
   assign rsp_stiffness  = rsp_stiff_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== sv/cst_divider.sv =====
// ----------------------------------------------------------------------------
// cst_divider
// Pipelined restoring divider, one quotient bit per stage. The partial
// remainder enters already below the divisor, so QUO_W stages give the full
// quotient.
// ----------------------------------------------------------------------------
module cst_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [cst_pkg::DVS_W-1:0]    in_rem,
   input  logic [cst_pkg::DVS_W-1:0]    in_dvs,
   input  logic [cst_pkg::QUO_W-1:0]    in_bits,
   input  cst_pkg::tag_type             in_tag,
   output logic                         out_valid,
   output logic [cst_pkg::QUO_W-1:0]    out_quo,
   output cst_pkg::tag_type             out_tag
);

   localparam int QW = cst_pkg::QUO_W;
   localparam int DW = cst_pkg::DVS_W;

   logic                valid_ff [1:QW];
   logic [QW-1:0]       quo_ff   [1:QW];
   cst_pkg::tag_type    tag_ff   [1:QW];
   logic [DW-1:0]       rem_ff   [1:QW-1];
   logic [DW-1:0]       dvs_ff   [1:QW-1];
   logic [QW-1:0]       bits_ff  [1:QW-1];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic                src_valid;
      logic [DW-1:0]       src_rem;
      logic [DW-1:0]       src_dvs;
      logic [QW-1:0]       src_bits;
      logic [QW-1:0]       src_quo;
      cst_pkg::tag_type    src_tag;
      logic [DW:0]         trial;
      logic [DW:0]         diff;
      logic                ge;

      if (s == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_rem   = in_rem;
         assign src_dvs   = in_dvs;
         assign src_bits  = in_bits;
         assign src_quo   = '0;
         assign src_tag   = in_tag;
      end else begin : g_body
         assign src_valid = valid_ff[s];
         assign src_rem   = rem_ff[s];
         assign src_dvs   = dvs_ff[s];
         assign src_bits  = bits_ff[s];
         assign src_quo   = quo_ff[s];
         assign src_tag   = tag_ff[s];
      end

      // trial subtract; the top bit of the difference is the borrow
      assign trial = {src_rem, src_bits[QW-1]};
      assign diff  = trial - {1'b0, src_dvs};
      assign ge    = ~diff[DW];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[s+1] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[s+1] <= {src_quo[QW-2:0], ge};
            tag_ff[s+1] <= src_tag;
         end
      end

      if (s < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[s+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
               dvs_ff[s+1]  <= src_dvs;
               bits_ff[s+1] <= {src_bits[QW-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

// ===== sv/cst_triangle_stiffness_chk.sv =====
// ----------------------------------------------------------------------------
// cst_triangle_stiffness_chk
// Port-level checks on the result channel of the stiffness block.
// ----------------------------------------------------------------------------
module cst_triangle_stiffness_chk (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_row_index,
   input logic [2:0]         rsp_col_index,
   input logic signed [63:0] rsp_stiffness,
   input logic               rsp_degenerate,
   input logic               rsp_last
);

   // a stalled beat stays valid and keeps its stiffness value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stiffness))
      else $error("stalled result beat changed");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == ((rsp_row_index == 3'd5) && (rsp_col_index == 3'd5))))
      else $error("last flag not on the final entry");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_stiffness == 64'sd0)
      else $error("degenerate triangle gave a non-zero entry");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_index <= 3'd5) && (rsp_col_index <= 3'd5))
      else $error("entry index out of range");

endmodule

bind cst_triangle_stiffness cst_triangle_stiffness_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_row_index  (rsp_row_index),
   .rsp_col_index  (rsp_col_index),
   .rsp_stiffness  (rsp_stiffness),
   .rsp_degenerate (rsp_degenerate),
   .rsp_last       (rsp_last)
);
